// ===== rtl/core/dc_median_dpcm_decoder_core_defines.svh =====
// Assertion helpers for the checker file dcmd_checker.sv.
`ifndef DC_MEDIAN_DPCM_DECODER_CORE_DEFINES_SVH
`define DC_MEDIAN_DPCM_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define DCMD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define DCMD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/dcmd_pkg.sv =====
package dcmd_pkg;

  localparam int MAX_ROW_BLOCKS = 256;
  localparam int DC_BITS        = 16;
  localparam int ROW_LIMIT      = 4096;
  localparam int NCOMP          = 3;

  localparam int RES_W    = 16;
  localparam int DC_OUT_W = 16;
  localparam int SUM_W    = ((DC_BITS > RES_W) ? DC_BITS : RES_W) + 1;

  localparam int COL_W = (MAX_ROW_BLOCKS > 1) ? $clog2(MAX_ROW_BLOCKS) : 1;
  localparam int ROW_W = $clog2(ROW_LIMIT);

  localparam int BPR_W   = 9;
  localparam int BROWS_W = 13;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_PER_ROW = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_ROWS     = 1'b1;

  localparam logic [BPR_W-1:0]   BPR_RESET   = 9'd40;
  localparam logic [BROWS_W-1:0] BROWS_RESET = 13'd30;

  localparam int IN_DATA_W  = NCOMP * RES_W;
  localparam int OUT_DATA_W = NCOMP * DC_OUT_W;
  localparam int LINE_W     = NCOMP * DC_BITS;

  typedef enum logic [1:0] {
    PRED_ZERO,
    PRED_LEFT,
    PRED_UP,
    PRED_MEDIAN
  } pred_mode_e;

  // Position of the block being accepted.
  typedef struct packed {
    logic [COL_W-1:0] col;
    pred_mode_e       mode;
    logic             frame_end;
  } pos_t;

  // Control from the pipeline to every lane.
  typedef struct packed {
    logic       adv;
    logic       bypass;
    pred_mode_e mode;
  } lane_ctl_t;

endpackage

// ===== rtl/core/dcmd_ram.sv =====
module dcmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/dcmd_lane.sv =====
module dcmd_lane import dcmd_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  lane_ctl_t                 ctl_i,
  input  logic signed [RES_W-1:0]   res_i,
  input  logic signed [DC_BITS-1:0] up_i,
  output logic signed [DC_BITS-1:0] rec_o
);

  localparam logic signed [SUM_W-1:0] SAT_HI =
    SUM_W'((64'sd1 <<< (DC_BITS - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

  logic signed [DC_BITS-1:0] left_q, left_d;
  logic signed [DC_BITS-1:0] ul_q, ul_d;
  logic signed [DC_BITS-1:0] up, lo, hi, med, pred, rec;
  logic signed [SUM_W-1:0]   sum;

  // Previous block was written in the same cycle this one read the line.
  assign up = ctl_i.bypass ? left_q : up_i;

  always_comb begin
    lo = (left_q < up) ? left_q : up;
    hi = (left_q < up) ? up : left_q;
    if (ul_q < lo) begin
      med = lo;
    end else if (ul_q > hi) begin
      med = hi;
    end else begin
      med = ul_q;
    end
  end

  always_comb begin
    case (ctl_i.mode)
      PRED_ZERO:   pred = '0;
      PRED_LEFT:   pred = left_q;
      PRED_UP:     pred = up;
      PRED_MEDIAN: pred = med;
      default:     pred = '0;
    endcase
  end

  always_comb begin
    sum = SUM_W'(res_i) + SUM_W'(pred);
    if (sum > SAT_HI) begin
      rec = DC_BITS'(SAT_HI);
    end else if (sum < SAT_LO) begin
      rec = DC_BITS'(SAT_LO);
    end else begin
      rec = DC_BITS'(sum);
    end
  end

  assign left_d = ctl_i.adv ? rec : left_q;
  assign ul_d   = ctl_i.adv ? up  : ul_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
      ul_q   <= '0;
    end else begin
      left_q <= left_d;
      ul_q   <= ul_d;
    end
  end

  assign rec_o = rec;

endmodule

// ===== rtl/core/dcmd_pos.sv =====
module dcmd_pos import dcmd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic [BPR_W-1:0]   blocks_per_row_i,
  input  logic [BROWS_W-1:0] block_rows_i,
  output pos_t               pos_o
);

  logic [COL_W-1:0] col_q, col_d, last_col_idx, col;
  logic [ROW_W-1:0] row_q, row_d, last_row_idx, row;
  logic             last_col, last_row;

  // Clamp the configured sizes to their legal range.
  always_comb begin
    if (blocks_per_row_i == '0) begin
      last_col_idx = '0;
    end else if (int'(blocks_per_row_i) > MAX_ROW_BLOCKS) begin
      last_col_idx = COL_W'(MAX_ROW_BLOCKS - 1);
    end else begin
      last_col_idx = COL_W'(blocks_per_row_i - BPR_W'(1));
    end
    if (block_rows_i == '0) begin
      last_row_idx = '0;
    end else if (int'(block_rows_i) > ROW_LIMIT) begin
      last_row_idx = ROW_W'(ROW_LIMIT - 1);
    end else begin
      last_row_idx = ROW_W'(block_rows_i - BROWS_W'(1));
    end
  end

  // A counter past a shrunken size sits on the last position.
  assign col      = (col_q >= last_col_idx) ? last_col_idx : col_q;
  assign row      = (row_q >= last_row_idx) ? last_row_idx : row_q;
  assign last_col = (col == last_col_idx);
  assign last_row = (row == last_row_idx);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (adv_i) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row + ROW_W'(1);
      end else begin
        col_d = col + COL_W'(1);
        row_d = row;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  always_comb begin
    pos_o.col       = col;
    pos_o.frame_end = last_col & last_row;
    if (row == '0 && col == '0) begin
      pos_o.mode = PRED_ZERO;
    end else if (row == '0) begin
      pos_o.mode = PRED_LEFT;
    end else if (col == '0) begin
      pos_o.mode = PRED_UP;
    end else begin
      pos_o.mode = PRED_MEDIAN;
    end
  end

endmodule

// ===== rtl/core/dc_median_dpcm_decoder_core.sv =====
// Flow: an accepted request passes the stage 1 and output registers before m_axis shows it.
// Throughput: one block triple per cycle unless m_axis stalls; each lane closes its
//   left-value feedback (median, add, saturate) combinationally, and the line store gives
//   one read and one write per cycle.
// Reset: clears block counters, pipeline valids and predictor registers, and loads
//   blocks_per_row = 40 and block_rows = 30; the line store is not cleared (no clearing pass).
module dc_median_dpcm_decoder_core import dcmd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Input requests
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // luma_residual, cb_residual, cr_residual
  // Result requests
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // luma_dc, cb_dc, cr_dc
  output logic                  m_axis_tlast,   // frame_end
  // Configuration writes
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [BPR_W-1:0]   bpr_q, bpr_d;
  logic [BROWS_W-1:0] brows_q, brows_d;

  always_comb begin
    bpr_d   = bpr_q;
    brows_d = brows_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BLOCKS_PER_ROW: bpr_d   = cfg_data_i[BPR_W-1:0];
        CFG_BLOCK_ROWS:     brows_d = cfg_data_i[BROWS_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control
  //   stage 0: accept, compute position, issue line-store read
  //   stage 1: predict and reconstruct in the lanes, write line store
  //   stage 2: output register
  // ---------------------------------------------------------------------------
  logic                  s1_valid_q, s1_valid_d;
  logic [COL_W-1:0]      s1_col_q;
  pred_mode_e            s1_mode_q;
  logic                  s1_fe_q;
  logic                  s1_byp_q;
  logic [IN_DATA_W-1:0]  s1_res_q;

  logic                  out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;
  logic                  out_last_q;

  logic                  accept, adv1;
  pos_t                  pos;

  // Advance stage 1 whenever the output register is empty or being drained, so a
  // new request can enter even while a finished result still waits.
  assign adv1          = s1_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~s1_valid_q | adv1;
  assign accept        = s_axis_tvalid & s_axis_tready;

  assign s1_valid_d  = accept | (s1_valid_q & ~adv1);
  assign out_valid_d = adv1 | (out_valid_q & ~m_axis_tready);

  dcmd_pos u_pos (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .adv_i           (accept),
    .blocks_per_row_i(bpr_q),
    .block_rows_i    (brows_q),
    .pos_o           (pos)
  );

  // ---------------------------------------------------------------------------
  // Line store: one entry per block column, three DC values each
  // ---------------------------------------------------------------------------
  logic [LINE_W-1:0]             line_rdata;
  logic [NCOMP-1:0][DC_BITS-1:0] rec;

  dcmd_ram #(
    .WIDTH(LINE_W),
    .DEPTH(MAX_ROW_BLOCKS)
  ) u_line (
    .clk_i  (clk_i),
    .we_i   (adv1),
    .waddr_i(s1_col_q),
    .wdata_i(rec),
    .re_i   (accept),
    .raddr_i(pos.col),
    .rdata_o(line_rdata)
  );

  // ---------------------------------------------------------------------------
  // Lanes: one per color component
  // ---------------------------------------------------------------------------
  lane_ctl_t lane_ctl;

  assign lane_ctl.adv    = adv1;
  assign lane_ctl.bypass = s1_byp_q;
  assign lane_ctl.mode   = s1_mode_q;

  for (genvar k = 0; k < NCOMP; k++) begin : g_lane
    dcmd_lane u_lane (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctl_i (lane_ctl),
      .res_i (s1_res_q[k*RES_W +: RES_W]),
      .up_i  (line_rdata[k*DC_BITS +: DC_BITS]),
      .rec_o (rec[k])
    );
  end

  // Merge the three lane results into one output word.
  always_comb begin
    out_data_d = out_data_q;
    if (adv1) begin
      for (int k = 0; k < NCOMP; k++) begin
        out_data_d[k*DC_OUT_W +: DC_OUT_W] = DC_OUT_W'(signed'(rec[k]));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpr_q       <= BPR_RESET;
      brows_q     <= BROWS_RESET;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      bpr_q       <= bpr_d;
      brows_q     <= brows_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload: no reset needed.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_col_q  <= pos.col;
      s1_mode_q <= pos.mode;
      s1_fe_q   <= pos.frame_end;
      s1_res_q  <= s_axis_tdata;
      // The block leaving stage 1 writes the line store in this same cycle;
      // when it hits the column just read, take its value from the lane instead.
      s1_byp_q  <= adv1 & (s1_col_q == pos.col);
    end
    if (adv1) begin
      out_last_q <= s1_fe_q;
    end
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// ===== rtl/core/dcmd_checker.sv =====
`include "dc_median_dpcm_decoder_core_defines.svh"

module dcmd_checker import dcmd_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  m_axis_tlast
);

  // Hold a stalled result.
  `DCMD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result changed")

  // Input may only back-pressure when both stages are full and the output is stalled.
  `DCMD_ASSERT_NOW(a_in_ready, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input stalled without output back-pressure")

  // A fresh result comes from an accepted request that passed the stage 1 and output registers.
  `DCMD_ASSERT_NOW(a_out_src, $rose(m_axis_tvalid), $past(s_axis_tvalid && s_axis_tready, 2), "result without a matching request")

endmodule

bind dc_median_dpcm_decoder_core dcmd_checker u_dcmd_checker (.*);
